>>> rtl/text_console_writer_defines.svh
// Assertion macros for the text console writer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// property holds at every edge out of reset
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// Shared types, constants and microcode ROM of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CELL_W   = 16;
  localparam int CURSOR_W = 11;
  localparam int UPC_W    = 5;

  localparam logic [7:0] BLANK_CHAR       = 8'd32;
  localparam logic [7:0] NEWLINE_CHAR     = 8'd10;
  localparam logic [7:0] RESET_BLANK_ATTR = 8'd15;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_BACK    = 3'd1,
    OP_SETPOS  = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_LATCH   = 3'd4,
    OP_READ    = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ADDR_SWEEP,
    ADDR_SHIFT,
    ADDR_CURSOR,
    ADDR_POS
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_BLANK,
    WD_INIT,
    WD_INPUT,
    WD_COPY
  } wdata_sel_e;

  typedef enum logic [1:0] {
    SW_HOLD,
    SW_CLR,
    SW_INC
  } sweep_op_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SCROLL,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_BACK,
    CUR_SETPOS,
    CUR_CLEAR,
    CUR_LATCH
  } cur_op_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_GOTO,
    BR_DISPATCH,
    BR_WAIT
  } br_e;

  typedef enum logic [2:0] {
    C_TRUE,
    C_PAST_END,
    C_NEWLINE,
    C_SWEEP_END,
    C_SCROLL_END,
    C_ABOVE_LIMIT,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic             we;
    logic             re;
    addr_sel_e        addr;
    wdata_sel_e       wd;
    sweep_op_e        sw;
    cur_op_e          cur;
    br_e              br;
    cond_e            cond;
    logic             neg;
    logic [UPC_W-1:0] target;
    logic             ready;
    logic             done;
  } ucode_t;

  typedef struct packed {
    logic past_end;
    logic newline;
    logic sweep_end;
    logic scroll_end;
    logic above_limit;
  } stat_t;

  // program steps
  localparam logic [UPC_W-1:0] S_INIT    = 5'd0;
  localparam logic [UPC_W-1:0] S_IDLE    = 5'd1;
  localparam logic [UPC_W-1:0] S_PUT     = 5'd2;
  localparam logic [UPC_W-1:0] S_SCR_RD  = 5'd3;
  localparam logic [UPC_W-1:0] S_SCR_WR  = 5'd4;
  localparam logic [UPC_W-1:0] S_SCR_BLK = 5'd5;
  localparam logic [UPC_W-1:0] S_SCR_CUR = 5'd6;
  localparam logic [UPC_W-1:0] S_PUT_CHR = 5'd7;
  localparam logic [UPC_W-1:0] S_PUT_WR  = 5'd8;
  localparam logic [UPC_W-1:0] S_PUT_NL  = 5'd9;
  localparam logic [UPC_W-1:0] S_BS      = 5'd10;
  localparam logic [UPC_W-1:0] S_BS_STEP = 5'd11;
  localparam logic [UPC_W-1:0] S_BS_BLK  = 5'd12;
  localparam logic [UPC_W-1:0] S_SETPOS  = 5'd13;
  localparam logic [UPC_W-1:0] S_CLR     = 5'd14;
  localparam logic [UPC_W-1:0] S_CLR_BLK = 5'd15;
  localparam logic [UPC_W-1:0] S_CLR_CUR = 5'd16;
  localparam logic [UPC_W-1:0] S_LATCH   = 5'd17;
  localparam logic [UPC_W-1:0] S_READ    = 5'd18;
  localparam logic [UPC_W-1:0] S_FINISH  = 5'd19;

  function automatic logic [UPC_W-1:0] dispatch(input logic [2:0] op);
    logic [UPC_W-1:0] s;
    case (op)
      OP_PUT:    s = S_PUT;
      OP_BACK:   s = S_BS;
      OP_SETPOS: s = S_SETPOS;
      OP_CLEAR:  s = S_CLR;
      OP_LATCH:  s = S_LATCH;
      OP_READ:   s = S_READ;
      default:   s = S_FINISH;
    endcase
    return s;
  endfunction

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '0;
    case (upc)
      S_INIT: begin
        w.we = 1'b1; w.addr = ADDR_SWEEP; w.wd = WD_INIT; w.sw = SW_INC;
        w.br = BR_GOTO; w.cond = C_SWEEP_END; w.neg = 1'b1; w.target = S_INIT;
      end
      S_IDLE: begin
        w.ready = 1'b1; w.br = BR_DISPATCH;
      end
      S_PUT: begin
        w.sw = SW_CLR;
        w.br = BR_GOTO; w.cond = C_PAST_END; w.neg = 1'b1; w.target = S_PUT_CHR;
      end
      S_SCR_RD: begin
        w.re = 1'b1; w.addr = ADDR_SHIFT; w.br = BR_NEXT;
      end
      S_SCR_WR: begin
        w.we = 1'b1; w.addr = ADDR_SWEEP; w.wd = WD_COPY; w.sw = SW_INC;
        w.br = BR_GOTO; w.cond = C_SCROLL_END; w.neg = 1'b1; w.target = S_SCR_RD;
      end
      S_SCR_BLK: begin
        w.we = 1'b1; w.addr = ADDR_SWEEP; w.wd = WD_BLANK; w.sw = SW_INC;
        w.br = BR_GOTO; w.cond = C_SWEEP_END; w.neg = 1'b1; w.target = S_SCR_BLK;
      end
      S_SCR_CUR: begin
        w.cur = CUR_SCROLL; w.br = BR_NEXT;
      end
      S_PUT_CHR: begin
        w.br = BR_GOTO; w.cond = C_NEWLINE; w.target = S_PUT_NL;
      end
      S_PUT_WR: begin
        w.we = 1'b1; w.addr = ADDR_CURSOR; w.wd = WD_INPUT; w.cur = CUR_ADVANCE;
        w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_PUT_NL: begin
        w.cur = CUR_NEWLINE; w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_BS: begin
        w.br = BR_GOTO; w.cond = C_ABOVE_LIMIT; w.neg = 1'b1; w.target = S_FINISH;
      end
      S_BS_STEP: begin
        w.cur = CUR_BACK; w.br = BR_NEXT;
      end
      S_BS_BLK: begin
        w.we = 1'b1; w.addr = ADDR_CURSOR; w.wd = WD_BLANK;
        w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_SETPOS: begin
        w.cur = CUR_SETPOS; w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_CLR: begin
        w.sw = SW_CLR; w.br = BR_NEXT;
      end
      S_CLR_BLK: begin
        w.we = 1'b1; w.addr = ADDR_SWEEP; w.wd = WD_BLANK; w.sw = SW_INC;
        w.br = BR_GOTO; w.cond = C_SWEEP_END; w.neg = 1'b1; w.target = S_CLR_BLK;
      end
      S_CLR_CUR: begin
        w.cur = CUR_CLEAR; w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_LATCH: begin
        w.cur = CUR_LATCH; w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_READ: begin
        w.re = 1'b1; w.addr = ADDR_POS;
        w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_FINISH;
      end
      S_FINISH: begin
        w.done = 1'b1; w.br = BR_WAIT; w.cond = C_OUT_BUSY; w.target = S_IDLE;
      end
      default: begin
        w.br = BR_GOTO; w.cond = C_TRUE; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/tcw_store.sv
// Cell store: single-port RAM of character/attribute pairs, registered read.
// Depends on tcw_pkg for the cell width.
module tcw_store #(
  parameter int DEPTH = 2000
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      addr_i,
  input  logic [tcw_pkg::CELL_W-1:0]    wdata_i,
  output logic [tcw_pkg::CELL_W-1:0]    rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcw_seq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
// Depends on tcw_pkg for the control word and the program.
module tcw_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [2:0]           opcode_i,
  input  tcw_pkg::stat_t       stat_i,
  input  logic                 out_busy_i,
  output tcw_pkg::ucode_t      ctrl_o
);
  import tcw_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           w;
  logic             c;

  assign w      = ucode_rom(upc_q);
  assign ctrl_o = w;

  always_comb begin
    case (w.cond)
      C_TRUE:        c = 1'b1;
      C_PAST_END:    c = stat_i.past_end;
      C_NEWLINE:     c = stat_i.newline;
      C_SWEEP_END:   c = stat_i.sweep_end;
      C_SCROLL_END:  c = stat_i.scroll_end;
      C_ABOVE_LIMIT: c = stat_i.above_limit;
      C_OUT_BUSY:    c = out_busy_i;
      default:       c = 1'b0;
    endcase
  end

  always_comb begin
    case (w.br)
      BR_NEXT:     upc_d = upc_q + 1'b1;
      BR_GOTO:     upc_d = (c ^ w.neg) ? w.target : upc_q + 1'b1;
      BR_DISPATCH: upc_d = accept_i ? dispatch(opcode_i) : upc_q;
      BR_WAIT:     upc_d = c ? upc_q : w.target;
      default:     upc_d = S_IDLE;
    endcase
  end

  // reset starts the blanking pass over the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/tcw_dp.sv
// Datapath: latched command, cursor, limit, sweep pointer, store address/data.
// Depends on tcw_pkg; driven by the control word from tcw_seq.
module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcw_pkg::ucode_t                     ctrl_i,
  input  logic                                accept_i,
  input  logic [2:0]                          opcode_i,
  input  logic [7:0]                          character_i,
  input  logic [7:0]                          attribute_i,
  input  logic [6:0]                          column_i,
  input  logic [4:0]                          line_i,
  input  logic [7:0]                          blank_attr_i,
  input  logic [tcw_pkg::CELL_W-1:0]          rdata_i,
  output logic                                mem_we_o,
  output logic                                mem_re_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_addr_o,
  output logic [tcw_pkg::CELL_W-1:0]          mem_wdata_o,
  output tcw_pkg::stat_t                      stat_o,
  output logic [tcw_pkg::CURSOR_W-1:0]        cursor_position_o,
  output logic [7:0]                          res_char_o,
  output logic [7:0]                          res_attr_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int PW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);

  logic [2:0]  op_q;
  logic [7:0]  char_q, attr_q;
  logic [6:0]  col_q;
  logic [4:0]  line_q;

  logic [PW-1:0] cur_q, cur_d, limit_q, limit_d, sweep_q, sweep_d;
  logic [RW-1:0] crow_q, crow_d;
  logic [CW-1:0] ccol_q, ccol_d;

  logic [PW-1:0]          pos;
  logic [PW-1:0]          sweep_shift;
  logic [PW+CURSOR_W-1:0] cur_wide;
  logic                   in_range;
  logic                   rd_hit;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q   <= opcode_i;
      char_q <= character_i;
      attr_q <= attribute_i;
      col_q  <= column_i;
      line_q <= line_i;
    end
  end

  assign in_range    = (int'(col_q) < COLUMNS) && (int'(line_q) < ROWS);
  assign pos         = PW'(line_q) * PW'(COLUMNS) + PW'(col_q);
  assign sweep_shift = sweep_q + PW'(COLUMNS);

  always_comb begin
    case (ctrl_i.addr)
      ADDR_SWEEP:  mem_addr_o = sweep_q[AW-1:0];
      ADDR_SHIFT:  mem_addr_o = sweep_shift[AW-1:0];
      ADDR_CURSOR: mem_addr_o = cur_q[AW-1:0];
      ADDR_POS:    mem_addr_o = pos[AW-1:0];
      default:     mem_addr_o = sweep_q[AW-1:0];
    endcase
  end

  always_comb begin
    case (ctrl_i.wd)
      WD_BLANK: mem_wdata_o = {BLANK_CHAR, blank_attr_i};
      WD_INIT:  mem_wdata_o = {BLANK_CHAR, RESET_BLANK_ATTR};
      WD_INPUT: mem_wdata_o = {char_q, attr_q};
      WD_COPY:  mem_wdata_o = rdata_i;
      default:  mem_wdata_o = {BLANK_CHAR, blank_attr_i};
    endcase
  end

  assign mem_we_o = ctrl_i.we;
  assign mem_re_o = ctrl_i.re;

  assign stat_o.past_end    = (cur_q == PW'(CELLS));
  assign stat_o.newline     = (char_q == NEWLINE_CHAR);
  assign stat_o.sweep_end   = (sweep_q == PW'(CELLS - 1));
  assign stat_o.scroll_end  = (sweep_q == PW'(CELLS - COLUMNS - 1));
  assign stat_o.above_limit = (cur_q > limit_q);

  always_comb begin
    case (ctrl_i.sw)
      SW_CLR:  sweep_d = '0;
      SW_INC:  sweep_d = sweep_q + 1'b1;
      default: sweep_d = sweep_q;
    endcase
  end

  // cursor kept both linear and as row/column so no divide is needed
  always_comb begin
    cur_d   = cur_q;
    crow_d  = crow_q;
    ccol_d  = ccol_q;
    limit_d = limit_q;
    case (ctrl_i.cur)
      CUR_SCROLL: begin
        cur_d  = PW'(CELLS - COLUMNS);
        crow_d = RW'(ROWS - 1);
        ccol_d = '0;
      end
      CUR_NEWLINE: begin
        cur_d  = cur_q + (PW'(COLUMNS) - PW'(ccol_q));
        crow_d = crow_q + 1'b1;
        ccol_d = '0;
      end
      CUR_ADVANCE: begin
        cur_d = cur_q + 1'b1;
        if (ccol_q == CW'(COLUMNS - 1)) begin
          ccol_d = '0;
          crow_d = crow_q + 1'b1;
        end else begin
          ccol_d = ccol_q + 1'b1;
        end
      end
      CUR_BACK: begin
        cur_d = cur_q - 1'b1;
        if (ccol_q == '0) begin
          ccol_d = CW'(COLUMNS - 1);
          crow_d = crow_q - 1'b1;
        end else begin
          ccol_d = ccol_q - 1'b1;
        end
      end
      CUR_SETPOS: begin
        if (in_range) begin
          cur_d  = pos;
          crow_d = RW'(line_q);
          ccol_d = CW'(col_q);
        end
      end
      CUR_CLEAR: begin
        cur_d  = '0;
        crow_d = '0;
        ccol_d = '0;
      end
      CUR_LATCH: limit_d = cur_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      crow_q  <= '0;
      ccol_q  <= '0;
      limit_q <= '0;
      sweep_q <= '0;
    end else begin
      cur_q   <= cur_d;
      crow_q  <= crow_d;
      ccol_q  <= ccol_d;
      limit_q <= limit_d;
      sweep_q <= sweep_d;
    end
  end

  assign cur_wide          = (PW + CURSOR_W)'(cur_q);
  assign cursor_position_o = cur_wide[CURSOR_W-1:0];

  assign rd_hit     = (op_q == OP_READ) && in_range;
  assign res_char_o = rd_hit ? rdata_i[15:8] : 8'd0;
  assign res_attr_o = rd_hit ? rdata_i[7:0]  : 8'd0;

endmodule

>>> rtl/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS store of character/attribute cells with a
// linear cursor and a backspace limit, driven one command item at a time by a
// microcoded sequencer stepping one control word per cycle over a single-port
// cell RAM, except while it waits for an item or for the output register. After
// reset a blanking pass over all cells runs before the first item is taken (the
// blank_attribute register can be written meanwhile). Put char writes the cell and
// advances, or for a newline moves to the next line; backspace above the limit
// steps back and blanks the cell, and at the limit does nothing. A put char with
// the cursor past the end first scrolls: it moves the rows up, with the read and
// the write of each cell in separate steps on the single-port RAM, then blanks the
// last row and moves the cursor. Clear all blanks every cell and then resets the
// cursor. The next item is taken while a finished result still waits in the
// output register. Depends on tcw_pkg, tcw_seq, tcw_dp, tcw_store, assertion macros.
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  character_i,
  input  logic [7:0]  attribute_i,
  input  logic [6:0]  column_i,
  input  logic [4:0]  line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cursor_position_o,
  output logic [7:0]  read_character_o,
  output logic [7:0]  read_attribute_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  ucode_t              ctrl;
  stat_t               stat;
  logic                accept;
  logic                out_busy;
  logic                out_load;
  logic [7:0]          blank_attr_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_addr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;
  logic [CURSOR_W-1:0] res_cursor;
  logic [7:0]          res_char, res_attr;

  logic                out_valid_q;
  logic [CURSOR_W-1:0] cursor_q;
  logic [7:0]          rd_char_q, rd_attr_q;

  assign in_stall_o = !ctrl.ready;
  assign accept     = in_valid_i && ctrl.ready;
  assign out_busy   = out_valid_q && out_stall_i;
  assign out_load   = ctrl.done && !out_busy;

  tcw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .accept_i          (accept),
    .opcode_i          (opcode_i),
    .character_i       (character_i),
    .attribute_i       (attribute_i),
    .column_i          (column_i),
    .line_i            (line_i),
    .blank_attr_i      (blank_attr_q),
    .rdata_i           (mem_rdata),
    .mem_we_o          (mem_we),
    .mem_re_o          (mem_re),
    .mem_addr_o        (mem_addr),
    .mem_wdata_o       (mem_wdata),
    .stat_o            (stat),
    .cursor_position_o (res_cursor),
    .res_char_o        (res_char),
    .res_attr_o        (res_attr)
  );

  tcw_store #(
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_attr_q <= RESET_BLANK_ATTR;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || out_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cursor_q  <= res_cursor;
      rd_char_q <= res_char;
      rd_attr_q <= res_attr;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = cursor_q;
  assign read_character_o  = rd_char_q;
  assign read_attribute_o  = rd_attr_q;

  // a finished command must wait while the previous result is still held
  `TCW_ASSERT_ALWAYS(a_no_overwrite, !(out_load && out_busy), "result overwritten while stalled")
  // the sequencer leaves the idle step as soon as an item is taken
  `TCW_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o, "second item taken while busy")

endmodule

>>> dv/text_console_writer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: a queue-fed driver and a monitor
// check every command reply against a screen model kept in the testbench.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 30000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] chr;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } command_t;

  typedef struct packed {
    logic [10:0] pos;
    logic [7:0]  rd_chr;
    logic [7:0]  rd_attr;
  } reply_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid  = 1'b0;
  command_t   cur_cmd   = '0;
  logic       out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [10:0] pos;
  logic [7:0]  rd_chr;
  logic [7:0]  rd_attr;

  text_console_writer dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (cur_cmd.op),
    .character_i       (cur_cmd.chr),
    .attribute_i       (cur_cmd.attr),
    .column_i          (cur_cmd.col),
    .line_i            (cur_cmd.row),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .cursor_position_o (pos),
    .read_character_o  (rd_chr),
    .read_attribute_o  (rd_attr)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  command_t    pending_cmds[$];
  reply_t      expected_replies[$];
  logic [15:0] console_cells [CELLS];  // {character, attribute}
  int          console_cursor;
  int          console_limit;
  logic [7:0]  blank_attr = RESET_BLANK_ATTR;

  int send_idle_pct = 36;
  int recv_idle_pct = 51;
  int queued_total  = 0;
  int reply_count   = 0;
  int mismatches    = 0;
  bit hold_go       = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Screen model: applies one accepted command and records the reply it must produce.
  task automatic execute_command(input command_t c);
    reply_t r;
    int     idx;
    int     i;
    bit     in_range;
    r = '0;
    in_range = (c.col < COLS) && (c.row < ROWS);
    idx = int'(c.row) * COLS + int'(c.col);
    case (c.op)
      OP_PUT: begin
        if (console_cursor >= CELLS) begin
          for (i = 0; i < CELLS - COLS; i++) console_cells[i] = console_cells[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) console_cells[i] = {BLANK_CHAR, blank_attr};
          console_cursor = CELLS - COLS;
        end
        if (c.chr == NEWLINE_CHAR) begin
          console_cursor = (console_cursor / COLS + 1) * COLS;
        end else begin
          console_cells[console_cursor] = {c.chr, c.attr};
          console_cursor++;
        end
      end
      OP_BACK: begin
        if (console_cursor > console_limit) begin
          console_cursor--;
          console_cells[console_cursor] = {BLANK_CHAR, blank_attr};
        end
      end
      OP_SETPOS: begin
        if (in_range) console_cursor = idx;
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) console_cells[i] = {BLANK_CHAR, blank_attr};
        console_cursor = 0;
      end
      OP_LATCH: console_limit = console_cursor;
      OP_READ: begin
        if (in_range) {r.rd_chr, r.rd_attr} = console_cells[idx];
      end
      default: ;
    endcase
    r.pos = console_cursor[10:0];
    expected_replies.push_back(r);
  endtask

  function automatic command_t make_cmd(input logic [2:0] op, input logic [7:0] chr,
                                        input logic [7:0] attr, input logic [6:0] col,
                                        input logic [4:0] row);
    command_t c;
    c.op   = op;
    c.chr  = chr;
    c.attr = attr;
    c.col  = col;
    c.row  = row;
    return c;
  endfunction

  function automatic command_t random_fields(input logic [2:0] op);
    return make_cmd(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    7'($urandom_range(127)), 5'($urandom_range(31)));
  endfunction

  function automatic void queue_cmd(input command_t c);
    pending_cmds.push_back(c);
    queued_total++;
  endfunction

  // One stretch of random stimulus: mostly a set position followed by typing,
  // with single noisy commands, rare clears and typing from wherever the cursor is.
  function automatic void push_burst();
    command_t c;
    int       pick;
    int       len;
    int       n;
    int       start_row;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // clear sweeps the whole store, so keep it rare
      queue_cmd(random_fields(OP_CLEAR));
    end else if (pick < 18) begin
      c = random_fields(3'($urandom_range(7)));
      if (c.op == OP_CLEAR) c.op = OP_READ;
      queue_cmd(c);
    end else if (pick < 23) begin
      len = $urandom_range(6, 1);
      for (n = 0; n < len; n++) queue_cmd(random_fields(OP_PUT));
    end else begin
      // bias toward the last rows so newlines reach past the end and scroll
      start_row = ($urandom_range(7) == 0) ? $urandom_range(ROWS - 1, ROWS - 2)
                                           : $urandom_range(ROWS - 1);
      c = random_fields(OP_SETPOS);
      c.col = 7'($urandom_range(COLS - 1));
      c.row = 5'(start_row);
      queue_cmd(c);
      if ($urandom_range(3) == 0) queue_cmd(random_fields(OP_LATCH));
      len = $urandom_range(14, 2);
      for (n = 0; n < len; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          c = random_fields(OP_PUT);
          if ($urandom_range(7) == 0) c.chr = NEWLINE_CHAR;
        end else if (pick < 82) begin
          c = random_fields(OP_BACK);
        end else if (pick < 85) begin
          c = random_fields(OP_LATCH);
        end else begin
          c = random_fields(OP_READ);
          c.col = 7'($urandom_range(COLS - 1));
          c.row = 5'($urandom_range(1) ? start_row : $urandom_range(ROWS - 1));
        end
        queue_cmd(c);
      end
    end
  endfunction

  task automatic program_blank_attr(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    blank_attr = v;
  endtask

  // Driver: the item on the port is held until taken, then the next one may follow.
  always @(posedge clk) begin : cmd_driver
    command_t nxt;
    if (rst_n && in_valid && !in_stall) execute_command(cur_cmd);
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        cur_cmd  <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: checks replies in order and drives the reply-side stall.
  always @(posedge clk) begin : reply_monitor
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      reply_count++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply, cursor %0d char %0d attr %0d", $time, pos, rd_chr,
                 rd_attr);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        check_field("cursor_position", want.pos, pos);
        check_field("read_character", want.rd_chr, rd_chr);
        check_field("read_attribute", want.rd_attr, rd_attr);
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_console_writer_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    int phase_end;
    for (i = 0; i < CELLS; i++) console_cells[i] = {BLANK_CHAR, RESET_BLANK_ATTR};
    console_cursor = 0;
    console_limit  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 51;
          phase_end     = 650;
        end
        1: begin
          program_blank_attr(8'h00);
          send_idle_pct = 51;
          recv_idle_pct = 36;
          phase_end     = 1300;
        end
        2: begin
          program_blank_attr(8'hFF);
          send_idle_pct = 0;
          recv_idle_pct = 0;
          phase_end     = 1625;
        end
        default: begin
          program_blank_attr(8'($urandom_range(254, 1)));
          phase_end = 1950;
        end
      endcase

      if (phase == 0) begin
        queue_cmd(make_cmd(OP_READ, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_PUT, 8'h41, 8'h00, 0, 0));
        queue_cmd(make_cmd(OP_PUT, 8'hFF, 8'hFF, 0, 0));
        queue_cmd(make_cmd(OP_PUT, 8'h00, 8'h5A, 0, 0));
        queue_cmd(make_cmd(OP_BACK, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_LATCH, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_BACK, 0, 0, 0, 0));    // at the limit: no effect
        queue_cmd(make_cmd(OP_READ, 0, 0, 1, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 7'(COLS - 1), 5'(ROWS - 1)));
        queue_cmd(make_cmd(OP_READ, 0, 0, 7'(COLS), 0)); // outside the screen
        queue_cmd(make_cmd(OP_READ, 0, 0, 127, 31));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 7'(COLS - 1), 5'(ROWS - 1)));
        queue_cmd(make_cmd(OP_PUT, 8'h5A, 8'h81, 0, 0));  // cursor goes past the end
        queue_cmd(make_cmd(OP_PUT, 8'h51, 8'h3C, 0, 0));  // scrolls first
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 7'(COLS), 3));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 5'(ROWS)));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 5, 5'(ROWS - 1)));
        queue_cmd(make_cmd(OP_PUT, NEWLINE_CHAR, 0, 0, 0)); // newline on the last row
        queue_cmd(make_cmd(OP_PUT, NEWLINE_CHAR, 0, 0, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 7'(COLS - 1), 5'(ROWS - 3)));
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_BACK, 0, 0, 0, 0));    // limit survives the clear
        queue_cmd(make_cmd(OP_SPARE_A, 8'hFF, 8'hFF, 127, 31));
        queue_cmd(make_cmd(OP_SPARE_B, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_READ, 0, 0, 1, 0));
      end
      while (queued_total < phase_end) push_burst();
      // sender keeps offering while the reply side holds off
      if (phase == 2) hold_go = 1'b1;

      while (reply_count < queued_total) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("text_console_writer_test passed");
    end else begin
      $display("text_console_writer_test failed");
    end
    $finish;
  end

endmodule
